[rtl/tmpr_pkg.sv]
// shared types, constants and palette for the text mode pixel renderer
`default_nettype none

package tmpr_pkg;

  // default screen and glyph geometry
  localparam int DEF_TEXT_COLS    = 50;
  localparam int DEF_TEXT_ROWS    = 30;
  localparam int DEF_GLYPH_WIDTH  = 9;
  localparam int DEF_GLYPH_HEIGHT = 9;

  // glyphs in the font
  localparam int GLYPH_COUNT = 256;

  // input field widths
  localparam int OPCODE_W   = 2;
  localparam int CELL_IDX_W = 11;
  localparam int CODE_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int GROW_W     = 4;
  localparam int ROW_BITS_W = 9;
  localparam int PIX_W      = 9;
  localparam int COLOR_W    = 16;
  localparam int CELL_W     = CODE_W + ATTR_W;
  localparam int RB_IDX_W   = $clog2(ROW_BITS_W);

  // input tdata layout, lowest field first
  localparam int CELL_IDX_LSB = 0;
  localparam int CODE_LSB     = CELL_IDX_LSB + CELL_IDX_W;
  localparam int ATTR_LSB     = CODE_LSB + CODE_W;
  localparam int GROW_LSB     = ATTR_LSB + ATTR_W;
  localparam int ROW_BITS_LSB = GROW_LSB + GROW_W;
  localparam int PX_LSB       = ROW_BITS_LSB + ROW_BITS_W;
  localparam int PY_LSB       = PX_LSB + PIX_W;
  localparam int IN_FIELDS_W  = PY_LSB + PIX_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = COLOR_W;

  // opcodes carried on in_tuser
  localparam logic [OPCODE_W-1:0] OP_CELL   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_GLYPH  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RENDER = 2'd2;

  // command kinds between front and back
  localparam int KIND_W = 2;
  typedef enum logic [KIND_W-1:0] {
    K_CELL,
    K_GLYPH,
    K_RENDER,
    K_BLACK
  } kind_t;

  // command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } q_stat_t;

  // rgb565 color components
  localparam logic [COLOR_W-1:0] BLUE_LO   = 16'h0015;
  localparam logic [COLOR_W-1:0] GREEN_LO  = 16'h0540;
  localparam logic [COLOR_W-1:0] RED_LO    = 16'ha800;
  localparam logic [COLOR_W-1:0] GREEN_DIM = 16'h02a0;
  localparam logic [COLOR_W-1:0] RED_DIM   = 16'h5000;
  localparam logic [COLOR_W-1:0] BLUE_DIM  = 16'h000a;
  localparam logic [COLOR_W-1:0] BLUE_HI   = 16'h001f;
  localparam logic [COLOR_W-1:0] GREEN_HI  = 16'h07e0;
  localparam logic [COLOR_W-1:0] RED_HI    = 16'hf800;

  // 16 color ega palette in rgb565
  function automatic logic [COLOR_W-1:0] palette565(input logic [3:0] idx);
    logic [COLOR_W-1:0] c;
    case (idx)
      4'd0:  c = '0;
      4'd1:  c = BLUE_LO;
      4'd2:  c = GREEN_LO;
      4'd3:  c = GREEN_LO | BLUE_LO;
      4'd4:  c = RED_LO;
      4'd5:  c = RED_LO | BLUE_LO;
      4'd6:  c = RED_LO | GREEN_DIM;
      4'd7:  c = RED_LO | GREEN_LO | BLUE_LO;
      4'd8:  c = RED_DIM | GREEN_DIM | BLUE_DIM;
      4'd9:  c = RED_DIM | GREEN_DIM | BLUE_HI;
      4'd10: c = RED_DIM | GREEN_HI | BLUE_DIM;
      4'd11: c = RED_DIM | GREEN_HI | BLUE_HI;
      4'd12: c = RED_HI | GREEN_DIM | BLUE_DIM;
      4'd13: c = RED_HI | GREEN_DIM | BLUE_HI;
      4'd14: c = RED_HI | GREEN_HI | BLUE_DIM;
      4'd15: c = RED_HI | GREEN_HI | BLUE_HI;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/text_mode_pixel_renderer.sv]
// top level of the text mode pixel renderer
//
// Text mode character generator: holds a TEXT_COLS x TEXT_ROWS store of character cells
// (code and color attribute) and a 256-glyph font of GLYPH_WIDTH x GLYPH_HEIGHT one-bit
// pixels, and turns render transactions into RGB565 pixel colors from the 16-color EGA
// palette (set font bit: low attribute nibble, clear bit: high nibble, off screen: black).
// Cell and glyph row writes go through the same input stream and produce no result.
// The block takes one transaction per clock and returns one color per clock while
// out_tready stays high; out_tvalid for a render rises once it has passed two front
// stages, the command queue, three back stages and the output register, the first
// front stage loading at its accepting edge. Each store is a single-port memory touched
// once per transaction, which sets the one-per-clock figure. After reset a clearing pass
// zeroes both stores, one entry per cycle for the larger of the two (the font at the
// default geometry), with in_tready held low.
`default_nettype none

module text_mode_pixel_renderer #(
  parameter int TEXT_COLS    = tmpr_pkg::DEF_TEXT_COLS,
  parameter int TEXT_ROWS    = tmpr_pkg::DEF_TEXT_ROWS,
  parameter int GLYPH_WIDTH  = tmpr_pkg::DEF_GLYPH_WIDTH,
  parameter int GLYPH_HEIGHT = tmpr_pkg::DEF_GLYPH_HEIGHT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // cell_index, char_code, attribute, glyph_row, row_bits, pixel_x, pixel_y, zero pad
  input  wire logic [tmpr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  wire logic [tmpr_pkg::OPCODE_W-1:0]    in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // pix_rgb
  output logic [tmpr_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  localparam int CELL_COUNT = TEXT_COLS * TEXT_ROWS;
  localparam int FONT_ROWS  = tmpr_pkg::GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int FONT_AW    = $clog2(FONT_ROWS);
  localparam int GX_W       = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
  localparam int GY_W       = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
  localparam int ENTRY_W    = tmpr_pkg::KIND_W + CELL_AW + FONT_AW + tmpr_pkg::CELL_W
                              + GX_W + GY_W;

  tmpr_pkg::q_stat_t  q_stat;
  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               pop;
  logic [ENTRY_W-1:0] head_data;
  logic               clearing;

  // accept and classify
  tmpr_front #(
    .TEXT_COLS   (TEXT_COLS),
    .TEXT_ROWS   (TEXT_ROWS),
    .GLYPH_WIDTH (GLYPH_WIDTH),
    .GLYPH_HEIGHT(GLYPH_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .hold     (clearing),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data)
  );

  // command queue
  tmpr_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head_data(head_data),
    .q_stat   (q_stat)
  );

  // stores and render pipeline
  tmpr_back #(
    .TEXT_COLS   (TEXT_COLS),
    .TEXT_ROWS   (TEXT_ROWS),
    .GLYPH_WIDTH (GLYPH_WIDTH),
    .GLYPH_HEIGHT(GLYPH_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_data (head_data),
    .pop       (pop),
    .clearing  (clearing),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

[rtl/tmpr_front.sv]
// front end: accepts transactions, classifies them and computes store addresses
`default_nettype none

module tmpr_front #(
  parameter int TEXT_COLS    = tmpr_pkg::DEF_TEXT_COLS,
  parameter int TEXT_ROWS    = tmpr_pkg::DEF_TEXT_ROWS,
  parameter int GLYPH_WIDTH  = tmpr_pkg::DEF_GLYPH_WIDTH,
  parameter int GLYPH_HEIGHT = tmpr_pkg::DEF_GLYPH_HEIGHT,
  localparam int CELL_COUNT = TEXT_COLS * TEXT_ROWS,
  localparam int FONT_ROWS  = tmpr_pkg::GLYPH_COUNT * GLYPH_HEIGHT,
  localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1,
  localparam int FONT_AW    = $clog2(FONT_ROWS),
  localparam int GX_W       = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1,
  localparam int GY_W       = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1,
  localparam int ENTRY_W    = tmpr_pkg::KIND_W + CELL_AW + FONT_AW + tmpr_pkg::CELL_W
                              + GX_W + GY_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [tmpr_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic [tmpr_pkg::OPCODE_W-1:0]   in_tuser,
  input  wire logic                            hold,
  input  wire tmpr_pkg::q_stat_t               q_stat,
  output logic                                 push,
  output logic [ENTRY_W-1:0]                   push_data
);

  // reciprocal for division of a pixel coordinate by the glyph size
  localparam int DIV_SHIFT = tmpr_pkg::PIX_W + 4;
  localparam int PROD_W    = tmpr_pkg::PIX_W + DIV_SHIFT + 1;
  localparam int X_MUL     = (2 ** DIV_SHIFT + GLYPH_WIDTH - 1) / GLYPH_WIDTH;
  localparam int Y_MUL     = (2 ** DIV_SHIFT + GLYPH_HEIGHT - 1) / GLYPH_HEIGHT;
  localparam int SCREEN_W  = TEXT_COLS * GLYPH_WIDTH;
  localparam int SCREEN_H  = TEXT_ROWS * GLYPH_HEIGHT;
  localparam int REM_W     = tmpr_pkg::PIX_W + 5;
  localparam int LIN_W     = tmpr_pkg::PIX_W + 8;
  localparam int FLIN_W    = tmpr_pkg::CODE_W + 5;
  localparam int CRED_W    = tmpr_pkg::QCNT_W + 1;

  logic [tmpr_pkg::CELL_IDX_W-1:0] f_idx;
  logic [tmpr_pkg::CODE_W-1:0]     f_code;
  logic [tmpr_pkg::ATTR_W-1:0]     f_attr;
  logic [tmpr_pkg::GROW_W-1:0]     f_grow;
  logic [tmpr_pkg::ROW_BITS_W-1:0] f_bits;
  logic [tmpr_pkg::PIX_W-1:0]      f_px;
  logic [tmpr_pkg::PIX_W-1:0]      f_py;
  logic [PROD_W-1:0]               prod_x;
  logic [PROD_W-1:0]               prod_y;
  logic [CRED_W-1:0]               credit;
  logic                            accept;
  logic                            keep;
  logic                            offscreen;
  tmpr_pkg::kind_t                 kind;

  logic                            a_valid_r;
  tmpr_pkg::kind_t                 a_kind_r;
  logic [CELL_AW-1:0]              a_idx_r;
  logic [tmpr_pkg::CODE_W-1:0]     a_code_r;
  logic [tmpr_pkg::ATTR_W-1:0]     a_attr_r;
  logic [GY_W-1:0]                 a_grow_r;
  logic [tmpr_pkg::ROW_BITS_W-1:0] a_bits_r;
  logic [tmpr_pkg::PIX_W-1:0]      a_px_r;
  logic [tmpr_pkg::PIX_W-1:0]      a_py_r;
  logic [tmpr_pkg::PIX_W-1:0]      a_col_r;
  logic [tmpr_pkg::PIX_W-1:0]      a_row_r;

  logic [REM_W-1:0]                gx_full;
  logic [REM_W-1:0]                gy_full;
  logic [LIN_W-1:0]                cell_lin;
  logic [FLIN_W-1:0]               font_lin;
  logic [CELL_AW-1:0]              b_cell_addr;
  logic [tmpr_pkg::CELL_W-1:0]     b_wdata;
  logic [ENTRY_W-1:0]              b_entry;

  logic                            b_valid_r;
  logic [ENTRY_W-1:0]              b_data_r;

  // field unpack
  always_comb begin
    f_idx  = in_tdata[tmpr_pkg::CELL_IDX_LSB +: tmpr_pkg::CELL_IDX_W];
    f_code = in_tdata[tmpr_pkg::CODE_LSB +: tmpr_pkg::CODE_W];
    f_attr = in_tdata[tmpr_pkg::ATTR_LSB +: tmpr_pkg::ATTR_W];
    f_grow = in_tdata[tmpr_pkg::GROW_LSB +: tmpr_pkg::GROW_W];
    f_bits = in_tdata[tmpr_pkg::ROW_BITS_LSB +: tmpr_pkg::ROW_BITS_W];
    f_px   = in_tdata[tmpr_pkg::PX_LSB +: tmpr_pkg::PIX_W];
    f_py   = in_tdata[tmpr_pkg::PY_LSB +: tmpr_pkg::PIX_W];
  end

  // credit check: everything in flight in front plus queue fill must fit the queue
  always_comb begin
    credit    = CRED_W'(q_stat.count) + CRED_W'(a_valid_r) + CRED_W'(b_valid_r);
    in_tready = !hold && (credit < CRED_W'(tmpr_pkg::QUEUE_DEPTH));
    accept    = in_tvalid && in_tready;
  end

  // classify the transaction, drop out-of-range writes and unused opcodes
  always_comb begin
    offscreen = (32'(f_px) >= SCREEN_W) || (32'(f_py) >= SCREEN_H);
    keep      = 1'b0;
    kind      = tmpr_pkg::K_RENDER;
    case (in_tuser)
      tmpr_pkg::OP_CELL: begin
        kind = tmpr_pkg::K_CELL;
        keep = 32'(f_idx) < CELL_COUNT;
      end
      tmpr_pkg::OP_GLYPH: begin
        kind = tmpr_pkg::K_GLYPH;
        keep = 32'(f_grow) < GLYPH_HEIGHT;
      end
      tmpr_pkg::OP_RENDER: begin
        kind = offscreen ? tmpr_pkg::K_BLACK : tmpr_pkg::K_RENDER;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // text column and row by reciprocal multiply
  always_comb begin
    prod_x = PROD_W'(f_px) * PROD_W'(X_MUL);
    prod_y = PROD_W'(f_py) * PROD_W'(Y_MUL);
  end

  // stage a
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind_r <= kind;
      a_idx_r  <= CELL_AW'(f_idx);
      a_code_r <= f_code;
      a_attr_r <= f_attr;
      a_grow_r <= GY_W'(f_grow);
      a_bits_r <= f_bits;
      a_px_r   <= f_px;
      a_py_r   <= f_py;
      a_col_r  <= prod_x[DIV_SHIFT +: tmpr_pkg::PIX_W];
      a_row_r  <= prod_y[DIV_SHIFT +: tmpr_pkg::PIX_W];
    end
  end

  // glyph offsets, cell address and font address
  always_comb begin
    gx_full  = REM_W'(a_px_r) - REM_W'(a_col_r) * REM_W'(GLYPH_WIDTH);
    gy_full  = REM_W'(a_py_r) - REM_W'(a_row_r) * REM_W'(GLYPH_HEIGHT);
    cell_lin = LIN_W'(a_row_r) * LIN_W'(TEXT_COLS) + LIN_W'(a_col_r);
    font_lin = FLIN_W'(a_code_r) * FLIN_W'(GLYPH_HEIGHT) + FLIN_W'(a_grow_r);
    case (a_kind_r)
      tmpr_pkg::K_CELL:   b_cell_addr = a_idx_r;
      tmpr_pkg::K_RENDER: b_cell_addr = cell_lin[CELL_AW-1:0];
      default:            b_cell_addr = '0;
    endcase
    if (a_kind_r == tmpr_pkg::K_CELL) begin
      b_wdata = {a_attr_r, a_code_r};
    end else begin
      b_wdata = tmpr_pkg::CELL_W'(a_bits_r);
    end
    b_entry = {a_kind_r, b_cell_addr, font_lin[FONT_AW-1:0], b_wdata,
               gx_full[GX_W-1:0], gy_full[GY_W-1:0]};
  end

  // stage b, feeds the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r) begin
      b_data_r <= b_entry;
    end
  end

  assign push      = b_valid_r;
  assign push_data = b_data_r;

endmodule

`default_nettype wire

[rtl/tmpr_queue.sv]
// short command queue between front and back
`default_nettype none

module tmpr_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head_data,
  output tmpr_pkg::q_stat_t     q_stat
);

  logic [WIDTH-1:0]            entry_r [tmpr_pkg::QUEUE_DEPTH];
  logic [tmpr_pkg::QPTR_W-1:0] wptr_r;
  logic [tmpr_pkg::QPTR_W-1:0] rptr_r;
  logic [tmpr_pkg::QCNT_W-1:0] count_r;
  logic                        do_pop;

  assign do_pop = pop && (count_r != '0);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == tmpr_pkg::QPTR_W'(tmpr_pkg::QUEUE_DEPTH - 1)) ? '0
                  : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == tmpr_pkg::QPTR_W'(tmpr_pkg::QUEUE_DEPTH - 1)) ? '0
                  : rptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head_data    = entry_r[rptr_r];
  assign q_stat.count = count_r;
  assign q_stat.empty = (count_r == '0);

endmodule

`default_nettype wire

[rtl/tmpr_back.sv]
// back end: cell and font stores, render pipeline and output register
`default_nettype none

module tmpr_back #(
  parameter int TEXT_COLS    = tmpr_pkg::DEF_TEXT_COLS,
  parameter int TEXT_ROWS    = tmpr_pkg::DEF_TEXT_ROWS,
  parameter int GLYPH_WIDTH  = tmpr_pkg::DEF_GLYPH_WIDTH,
  parameter int GLYPH_HEIGHT = tmpr_pkg::DEF_GLYPH_HEIGHT,
  localparam int CELL_COUNT = TEXT_COLS * TEXT_ROWS,
  localparam int FONT_ROWS  = tmpr_pkg::GLYPH_COUNT * GLYPH_HEIGHT,
  localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1,
  localparam int FONT_AW    = $clog2(FONT_ROWS),
  localparam int GX_W       = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1,
  localparam int GY_W       = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1,
  localparam int ENTRY_W    = tmpr_pkg::KIND_W + CELL_AW + FONT_AW + tmpr_pkg::CELL_W
                              + GX_W + GY_W
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire tmpr_pkg::q_stat_t                q_stat,
  input  wire logic [ENTRY_W-1:0]               head_data,
  output logic                                  pop,
  output logic                                  clearing,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [tmpr_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  // entry layout, lowest field first
  localparam int GY_LSB    = 0;
  localparam int GX_LSB    = GY_LSB + GY_W;
  localparam int WD_LSB    = GX_LSB + GX_W;
  localparam int FA_LSB    = WD_LSB + tmpr_pkg::CELL_W;
  localparam int CA_LSB    = FA_LSB + FONT_AW;
  localparam int KD_LSB    = CA_LSB + CELL_AW;
  localparam int CLEAR_LEN = (CELL_COUNT > FONT_ROWS) ? CELL_COUNT : FONT_ROWS;
  localparam int CLR_W     = $clog2(CLEAR_LEN);
  localparam int FLIN_W    = tmpr_pkg::CODE_W + 5;

  logic [tmpr_pkg::CELL_W-1:0]     cell_mem [CELL_COUNT];
  logic [tmpr_pkg::ROW_BITS_W-1:0] font_mem [FONT_ROWS];

  tmpr_pkg::kind_t                 h_kind;
  logic [CELL_AW-1:0]              h_cell_addr;
  logic [FONT_AW-1:0]              h_font_addr;
  logic [tmpr_pkg::CELL_W-1:0]     h_wdata;
  logic [GX_W-1:0]                 h_gx;
  logic [GY_W-1:0]                 h_gy;

  logic                            adv;
  logic                            clearing_r;
  logic [CLR_W-1:0]                clr_cnt_r;

  logic                            cell_we;
  logic [CELL_AW-1:0]              cell_wa;
  logic [tmpr_pkg::CELL_W-1:0]     cell_wd;
  logic [tmpr_pkg::CELL_W-1:0]     cell_rd_r;

  logic                            s1_valid_r;
  tmpr_pkg::kind_t                 s1_kind_r;
  logic [FONT_AW-1:0]              s1_fa_r;
  logic [tmpr_pkg::ROW_BITS_W-1:0] s1_bits_r;
  logic [GX_W-1:0]                 s1_gx_r;
  logic [GY_W-1:0]                 s1_gy_r;
  logic [FLIN_W-1:0]               font_lin;
  logic [FONT_AW-1:0]              s2_fa_nxt;

  logic                            s2_valid_r;
  tmpr_pkg::kind_t                 s2_kind_r;
  logic [FONT_AW-1:0]              s2_fa_r;
  logic [tmpr_pkg::ROW_BITS_W-1:0] s2_bits_r;
  logic [GX_W-1:0]                 s2_gx_r;
  logic [tmpr_pkg::ATTR_W-1:0]     s2_attr_r;

  logic                            font_we;
  logic [FONT_AW-1:0]              font_wa;
  logic [tmpr_pkg::ROW_BITS_W-1:0] font_wd;
  logic [tmpr_pkg::ROW_BITS_W-1:0] font_rd_r;

  logic                            s3_valid_r;
  tmpr_pkg::kind_t                 s3_kind_r;
  logic [GX_W-1:0]                 s3_gx_r;
  logic [tmpr_pkg::ATTR_W-1:0]     s3_attr_r;

  logic [GX_W-1:0]                 sel;
  logic                            fg;
  logic [tmpr_pkg::COLOR_W-1:0]    color_nxt;
  logic                            out_valid_r;
  logic [tmpr_pkg::COLOR_W-1:0]    out_color_r;

  // queue head unpack
  always_comb begin
    h_kind      = tmpr_pkg::kind_t'(head_data[KD_LSB +: tmpr_pkg::KIND_W]);
    h_cell_addr = head_data[CA_LSB +: CELL_AW];
    h_font_addr = head_data[FA_LSB +: FONT_AW];
    h_wdata     = head_data[WD_LSB +: tmpr_pkg::CELL_W];
    h_gx        = head_data[GX_LSB +: GX_W];
    h_gy        = head_data[GY_LSB +: GY_W];
  end

  // whole back pipeline moves when the output register can take a result
  assign adv      = !out_valid_r || out_tready;
  assign pop      = adv && !q_stat.empty && !clearing_r;
  assign clearing = clearing_r;

  // clearing pass over both stores after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == CLR_W'(CLEAR_LEN - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // cell store port: cell writes and render lookups in queue order
  always_comb begin
    if (clearing_r) begin
      cell_we = 32'(clr_cnt_r) < CELL_COUNT;
      cell_wa = clr_cnt_r[CELL_AW-1:0];
      cell_wd = '0;
    end else begin
      cell_we = pop && (h_kind == tmpr_pkg::K_CELL);
      cell_wa = h_cell_addr;
      cell_wd = h_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_wa] <= cell_wd;
    end
    if (adv) begin
      cell_rd_r <= cell_mem[h_cell_addr];
    end
  end

  // stage 1: cell data arrives
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r <= h_kind;
      s1_fa_r   <= h_font_addr;
      s1_bits_r <= h_wdata[tmpr_pkg::ROW_BITS_W-1:0];
      s1_gx_r   <= h_gx;
      s1_gy_r   <= h_gy;
    end
  end

  // font address from the character code, or the write address
  always_comb begin
    font_lin = FLIN_W'(cell_rd_r[tmpr_pkg::CODE_W-1:0]) * FLIN_W'(GLYPH_HEIGHT)
               + FLIN_W'(s1_gy_r);
    if (s1_kind_r == tmpr_pkg::K_GLYPH) begin
      s2_fa_nxt = s1_fa_r;
    end else begin
      s2_fa_nxt = font_lin[FONT_AW-1:0];
    end
  end

  // stage 2: font access
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind_r <= s1_kind_r;
      s2_fa_r   <= s2_fa_nxt;
      s2_bits_r <= s1_bits_r;
      s2_gx_r   <= s1_gx_r;
      s2_attr_r <= cell_rd_r[tmpr_pkg::CELL_W-1:tmpr_pkg::CODE_W];
    end
  end

  // font store port: glyph writes and render lookups in queue order
  always_comb begin
    if (clearing_r) begin
      font_we = 32'(clr_cnt_r) < FONT_ROWS;
      font_wa = clr_cnt_r[FONT_AW-1:0];
      font_wd = '0;
    end else begin
      font_we = adv && s2_valid_r && (s2_kind_r == tmpr_pkg::K_GLYPH);
      font_wa = s2_fa_r;
      font_wd = s2_bits_r;
    end
  end

  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[font_wa] <= font_wd;
    end
    if (adv) begin
      font_rd_r <= font_mem[s2_fa_r];
    end
  end

  // stage 3: glyph row arrives
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_kind_r <= s2_kind_r;
      s3_gx_r   <= s2_gx_r;
      s3_attr_r <= s2_attr_r;
    end
  end

  // pixel bit select, leftmost pixel in the top bit, then palette
  always_comb begin
    sel = GX_W'(GLYPH_WIDTH - 1) - s3_gx_r;
    fg  = (32'(sel) < tmpr_pkg::ROW_BITS_W) && font_rd_r[tmpr_pkg::RB_IDX_W'(sel)];
    if (s3_kind_r == tmpr_pkg::K_BLACK) begin
      color_nxt = '0;
    end else if (fg) begin
      color_nxt = tmpr_pkg::palette565(s3_attr_r[3:0]);
    end else begin
      color_nxt = tmpr_pkg::palette565(s3_attr_r[7:4]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid_r && ((s3_kind_r == tmpr_pkg::K_RENDER) ||
                                    (s3_kind_r == tmpr_pkg::K_BLACK));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_color_r <= color_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_color_r;

endmodule

`default_nettype wire

[rtl/tmpr_checker.sv]
// port-level checker for the text mode pixel renderer, bound to the top level
`default_nettype none

module tmpr_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [tmpr_pkg::OPCODE_W-1:0]    in_tuser,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [tmpr_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [3:0] pending_r;
  logic       render_in;
  logic       result_out;

  assign render_in  = in_tvalid && in_tready && (in_tuser == tmpr_pkg::OP_RENDER);
  assign result_out = out_tvalid && out_tready;

  // render transactions accepted but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (render_in && !result_out) begin
      pending_r <= pending_r + 1'b1;
    end else if (result_out && !render_in) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  // a stalled result holds its color
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // input is closed right after reset, when the clearing of the stores begins
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("input open right after reset");

  // a result only answers an accepted render
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pending_r != '0)
    else $error("result without a pending render");

  // front credit and back pipeline bound the renders in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 4'd8)
    else $error("too many renders in flight");

endmodule

bind text_mode_pixel_renderer tmpr_checker u_tmpr_checker (.*);

`default_nettype wire

[bench/text_mode_pixel_renderer_tb.sv]
// self-checking testbench for the text mode pixel renderer
`timescale 1ns / 1ps

module text_mode_pixel_renderer_tb;

  // geometry of the block under test
  localparam int COLS       = tmpr_pkg::DEF_TEXT_COLS;
  localparam int ROWS       = tmpr_pkg::DEF_TEXT_ROWS;
  localparam int GW         = tmpr_pkg::DEF_GLYPH_WIDTH;
  localparam int GH         = tmpr_pkg::DEF_GLYPH_HEIGHT;
  localparam int CELL_COUNT = COLS * ROWS;
  localparam int FONT_ROWS  = tmpr_pkg::GLYPH_COUNT * GH;
  localparam int SCREEN_W   = COLS * GW;
  localparam int SCREEN_H   = ROWS * GH;

  // opcodes, short names for the stimulus table
  localparam logic [tmpr_pkg::OPCODE_W-1:0] CELL_WR  = tmpr_pkg::OP_CELL;
  localparam logic [tmpr_pkg::OPCODE_W-1:0] GLYPH_WR = tmpr_pkg::OP_GLYPH;
  localparam logic [tmpr_pkg::OPCODE_W-1:0] RENDER   = tmpr_pkg::OP_RENDER;
  // opcode the block leaves unused
  localparam logic [tmpr_pkg::OPCODE_W-1:0] OP_SPARE = 2'd3;

  // run length and settling time after the last result
  localparam int RANDOM_ITEMS = 900;
  localparam int SETTLE       = 24;
  localparam int NDIR         = 25;

  // ega colors in rgb565, index 0 to 15
  localparam logic [tmpr_pkg::COLOR_W-1:0] EGA565 [16] = '{
    16'h0000, 16'h0015, 16'h0540, 16'h0555, 16'ha800, 16'ha815, 16'haaa0, 16'had55,
    16'h52aa, 16'h52bf, 16'h57ea, 16'h57ff, 16'hfaaa, 16'hfabf, 16'hffea, 16'hffff
  };

  // one input transaction, plus a typed-in color where the row carries one
  typedef struct packed {
    logic [tmpr_pkg::OPCODE_W-1:0]   op;
    logic [tmpr_pkg::CELL_IDX_W-1:0] idx;
    logic [tmpr_pkg::CODE_W-1:0]     code;
    logic [tmpr_pkg::ATTR_W-1:0]     attr;
    logic [tmpr_pkg::GROW_W-1:0]     grow;
    logic [tmpr_pkg::ROW_BITS_W-1:0] bits;
    logic [tmpr_pkg::PIX_W-1:0]      px;
    logic [tmpr_pkg::PIX_W-1:0]      py;
    logic                            typed;
    logic [tmpr_pkg::COLOR_W-1:0]    want;
  } txn_t;

  // directed rows: op, cell, code, attr, glyph row, row bits, x, y, typed, color
  localparam txn_t DIRECTED [NDIR] = '{
    // blank screen after reset, corners and off-screen pixels
    '{RENDER,   11'd0,    8'h00, 8'h00, 4'd0,  9'h000, 9'd0,   9'd0,   1'b1, 16'h0000},
    '{RENDER,   11'd0,    8'h00, 8'h00, 4'd0,  9'h000, 9'd449, 9'd269, 1'b0, 16'h0000},
    '{RENDER,   11'd0,    8'h00, 8'h00, 4'd0,  9'h000, 9'd450, 9'd0,   1'b1, 16'h0000},
    '{RENDER,   11'd0,    8'h00, 8'h00, 4'd0,  9'h000, 9'd0,   9'd270, 1'b1, 16'h0000},
    '{RENDER,   11'd0,    8'h00, 8'h00, 4'd0,  9'h000, 9'd511, 9'd511, 1'b1, 16'h0000},
    // top-left cell, glyph 255 with only the leftmost pixel of row 0 set
    '{CELL_WR,  11'd0,    8'hff, 8'hf1, 4'd0,  9'h000, 9'd0,   9'd0,   1'b0, 16'h0000},
    '{GLYPH_WR, 11'd0,    8'hff, 8'h00, 4'd0,  9'h100, 9'd0,   9'd0,   1'b0, 16'h0000},
    '{RENDER,   11'd0,    8'h00, 8'h00, 4'd0,  9'h000, 9'd0,   9'd0,   1'b1, 16'h0015},
    '{RENDER,   11'd0,    8'h00, 8'h00, 4'd0,  9'h000, 9'd1,   9'd0,   1'b1, 16'hffff},
    '{RENDER,   11'd0,    8'h00, 8'h00, 4'd0,  9'h000, 9'd8,   9'd8,   1'b0, 16'h0000},
    // bottom-right cell, glyph 0 with only the rightmost pixel of row 8 set
    '{CELL_WR,  11'd1499, 8'h00, 8'h7e, 4'd0,  9'h000, 9'd0,   9'd0,   1'b0, 16'h0000},
    '{GLYPH_WR, 11'd0,    8'h00, 8'h00, 4'd8,  9'h001, 9'd0,   9'd0,   1'b0, 16'h0000},
    '{RENDER,   11'd0,    8'h00, 8'h00, 4'd0,  9'h000, 9'd449, 9'd269, 1'b1, 16'hffea},
    '{RENDER,   11'd0,    8'h00, 8'h00, 4'd0,  9'h000, 9'd448, 9'd269, 1'b1, 16'had55},
    // writes that must be dropped: cell past the screen, glyph row past the glyph
    '{CELL_WR,  11'd1500, 8'h12, 8'h34, 4'd0,  9'h000, 9'd0,   9'd0,   1'b0, 16'h0000},
    '{CELL_WR,  11'd2047, 8'hff, 8'hff, 4'd0,  9'h000, 9'd0,   9'd0,   1'b0, 16'h0000},
    '{GLYPH_WR, 11'd0,    8'hff, 8'h00, 4'd9,  9'h1ff, 9'd0,   9'd0,   1'b0, 16'h0000},
    '{GLYPH_WR, 11'd0,    8'hff, 8'h00, 4'd15, 9'h1ff, 9'd0,   9'd0,   1'b0, 16'h0000},
    '{RENDER,   11'd0,    8'h00, 8'h00, 4'd0,  9'h000, 9'd1,   9'd0,   1'b1, 16'hffff},
    // unused opcode gives no result
    '{OP_SPARE, 11'd0,    8'hff, 8'hff, 4'd0,  9'h1ff, 9'd0,   9'd0,   1'b0, 16'h0000},
    // full glyph row in a second cell
    '{GLYPH_WR, 11'd0,    8'h55, 8'h00, 4'd4,  9'h1ff, 9'd0,   9'd0,   1'b0, 16'h0000},
    '{CELL_WR,  11'd51,   8'h55, 8'h80, 4'd0,  9'h000, 9'd0,   9'd0,   1'b0, 16'h0000},
    '{RENDER,   11'd0,    8'h00, 8'h00, 4'd0,  9'h000, 9'd13,  9'd13,  1'b0, 16'h0000},
    '{RENDER,   11'd0,    8'h00, 8'h00, 4'd0,  9'h000, 9'd17,  9'd12,  1'b0, 16'h0000},
    '{RENDER,   11'd0,    8'h00, 8'h00, 4'd0,  9'h000, 9'd449, 9'd0,   1'b0, 16'h0000}
  };

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [tmpr_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [tmpr_pkg::OPCODE_W-1:0]    in_tuser   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [tmpr_pkg::OUT_TDATA_W-1:0] out_tdata;

  // shadow copy of the cell and font stores
  logic [tmpr_pkg::CELL_W-1:0]     cell_mem [CELL_COUNT];
  logic [tmpr_pkg::ROW_BITS_W-1:0] font_mem [FONT_ROWS];

  // colors still owed by the block, oldest first
  logic [tmpr_pkg::COLOR_W-1:0] color_queue [$];

  int errors    = 0;
  int checked   = 0;
  int sent      = 0;
  int n_render  = 0;
  int n_cell    = 0;
  int n_glyph   = 0;
  int n_dropped = 0;
  int cyc       = 0;
  int stall_left = 0;

  text_mode_pixel_renderer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // cell_index, char_code, attribute, glyph_row, row_bits, x, y
    .in_tuser   (in_tuser),   // opcode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // pix_rgb
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // pack the fields of a transaction into in_tdata
  function automatic logic [tmpr_pkg::IN_TDATA_W-1:0] pack_tdata(input txn_t t);
    logic [tmpr_pkg::IN_TDATA_W-1:0] d;
    d = '0;
    d[tmpr_pkg::CELL_IDX_LSB +: tmpr_pkg::CELL_IDX_W] = t.idx;
    d[tmpr_pkg::CODE_LSB +: tmpr_pkg::CODE_W]         = t.code;
    d[tmpr_pkg::ATTR_LSB +: tmpr_pkg::ATTR_W]         = t.attr;
    d[tmpr_pkg::GROW_LSB +: tmpr_pkg::GROW_W]         = t.grow;
    d[tmpr_pkg::ROW_BITS_LSB +: tmpr_pkg::ROW_BITS_W] = t.bits;
    d[tmpr_pkg::PX_LSB +: tmpr_pkg::PIX_W]            = t.px;
    d[tmpr_pkg::PY_LSB +: tmpr_pkg::PIX_W]            = t.py;
    return d;
  endfunction

  // color of one screen pixel from the shadow stores
  function automatic logic [tmpr_pkg::COLOR_W-1:0] pixel_at(
    input logic [tmpr_pkg::PIX_W-1:0] px,
    input logic [tmpr_pkg::PIX_W-1:0] py
  );
    int                              gx;
    int                              gy;
    logic [tmpr_pkg::CELL_W-1:0]     code_attr;
    logic [tmpr_pkg::ROW_BITS_W-1:0] line;
    if (int'(px) >= SCREEN_W || int'(py) >= SCREEN_H) return '0;
    gx        = int'(px) % GW;
    gy        = int'(py) % GH;
    code_attr = cell_mem[(int'(py) / GH) * COLS + (int'(px) / GW)];
    line      = font_mem[int'(code_attr[tmpr_pkg::CODE_W-1:0]) * GH + gy];
    return line[GW-1-gx] ? EGA565[code_attr[tmpr_pkg::CODE_W +: 4]]
                         : EGA565[code_attr[tmpr_pkg::CELL_W-4 +: 4]];
  endfunction

  // true when a transaction changes state or asks for a pixel
  function automatic bit takes_effect(input txn_t t);
    case (t.op)
      tmpr_pkg::OP_CELL:   return int'(t.idx) < CELL_COUNT;
      tmpr_pkg::OP_GLYPH:  return int'(t.grow) < GH;
      tmpr_pkg::OP_RENDER: return 1'b1;
      default:             return 1'b0;
    endcase
  endfunction

  // apply an accepted transaction to the shadow stores and queue its color
  task automatic apply_txn(input txn_t t);
    if (!takes_effect(t)) begin
      n_dropped++;
    end else begin
      case (t.op)
        tmpr_pkg::OP_CELL: begin
          cell_mem[t.idx] = {t.attr, t.code};
          n_cell++;
        end
        tmpr_pkg::OP_GLYPH: begin
          font_mem[int'(t.code) * GH + int'(t.grow)] = t.bits;
          n_glyph++;
        end
        default: begin
          color_queue.push_back(t.typed ? t.want : pixel_at(t.px, t.py));
          n_render++;
        end
      endcase
    end
  endtask

  // sender gap: mostly none or short, sometimes long, none in quiet phases
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((sent / 64) % 4 == 3) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random transaction, mostly well-formed and aimed at a small cell window
  function automatic txn_t random_txn();
    txn_t t;
    int   pick;
    int   aim;
    t       = '0;
    t.idx   = tmpr_pkg::CELL_IDX_W'($urandom);
    t.code  = tmpr_pkg::CODE_W'($urandom);
    t.attr  = tmpr_pkg::ATTR_W'($urandom);
    t.grow  = tmpr_pkg::GROW_W'($urandom);
    t.bits  = tmpr_pkg::ROW_BITS_W'($urandom);
    t.px    = tmpr_pkg::PIX_W'($urandom);
    t.py    = tmpr_pkg::PIX_W'($urandom);
    pick    = $urandom_range(0, 99);
    aim     = $urandom_range(0, 9);
    if (pick < 25) begin
      t.op = CELL_WR;
      if (aim < 7) begin
        t.idx  = tmpr_pkg::CELL_IDX_W'($urandom_range(0, 1) * COLS + $urandom_range(0, 9));
        t.code = tmpr_pkg::CODE_W'($urandom_range(0, 7));
      end else if (aim < 9) begin
        t.idx = tmpr_pkg::CELL_IDX_W'($urandom_range(0, CELL_COUNT - 1));
      end
    end else if (pick < 50) begin
      t.op = GLYPH_WR;
      if (aim < 7) begin
        t.code = tmpr_pkg::CODE_W'($urandom_range(0, 7));
        t.grow = tmpr_pkg::GROW_W'($urandom_range(0, GH - 1));
      end else if (aim < 9) begin
        t.grow = tmpr_pkg::GROW_W'($urandom_range(0, GH - 1));
      end
    end else if (pick < 96) begin
      t.op = RENDER;
      if (aim < 6) begin
        t.px = tmpr_pkg::PIX_W'($urandom_range(0, 10 * GW - 1));
        t.py = tmpr_pkg::PIX_W'($urandom_range(0, 2 * GH - 1));
      end else if (aim < 9) begin
        t.px = tmpr_pkg::PIX_W'($urandom_range(0, SCREEN_W - 1));
        t.py = tmpr_pkg::PIX_W'($urandom_range(0, SCREEN_H - 1));
      end
    end else begin
      t.op = OP_SPARE;
    end
    return t;
  endfunction

  // drive one transaction and wait for the handshake
  task automatic send_txn(input txn_t t);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= t.op;
    in_tdata  <= pack_tdata(t);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_txn(t);
    sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off the sender until every owed color has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (color_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // receiver backpressure: short and long stalls, with stall-free phases
  always @(posedge clk) begin
    int r;
    cyc++;
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      r = $urandom_range(0, 99);
      if (((cyc / 512) % 4) != 1) begin
        if (r < 25) stall_left = $urandom_range(1, 3);
        else if (r < 29) stall_left = $urandom_range(10, 40);
      end
    end
  end

  // compare each result transaction with the oldest owed color
  always @(posedge clk) begin
    logic [tmpr_pkg::COLOR_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (color_queue.size() == 0) begin
        $error("pix_rgb: no result expected, got %h", out_tdata);
        errors++;
      end else begin
        want = color_queue.pop_front();
        checked++;
        if (out_tdata !== want) begin
          $error("pix_rgb: expected %h, got %h", want, out_tdata);
          errors++;
        end
      end
    end
  end

  // reset, directed table, random traffic, final verdict
  initial begin
    int   counted;
    txn_t t;
    foreach (cell_mem[i]) cell_mem[i] = '0;
    foreach (font_mem[i]) font_mem[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NDIR; i++) send_txn(DIRECTED[i]);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      t = random_txn();
      send_txn(t);
      if (takes_effect(t)) counted++;
      if (counted == RANDOM_ITEMS / 2 && takes_effect(t)) drain_results();
    end
    drain_results();

    $display("sent %0d transactions: %0d renders, %0d cell writes, %0d glyph writes,",
             sent, n_render, n_cell, n_glyph);
    $display("%0d dropped; checked %0d pixel colors, %0d mismatches",
             n_dropped, checked, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
